// File: rtl/tagged_line_field_parser_unit_macros.svh
// Assertion macros for the tagged line field parser.
// Included by the top level; no other dependencies.
`ifndef TAGGED_LINE_FIELD_PARSER_UNIT_MACROS_SVH
`define TAGGED_LINE_FIELD_PARSER_UNIT_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define TLFP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlfp: same-cycle check failed");

// antecedent in a cycle implies consequent in the next cycle
`define TLFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlfp: next-cycle check failed");

`endif

// File: rtl/tlfp_pkg.sv
// Package for the tagged line field parser: widths, character codes,
// matcher phase types and the result record. No dependencies.
package tlfp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RES_W      = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int DATA_OUT_W = 48;

  typedef logic [VALUE_BITS-1:0] mag_t;
  typedef logic [7:0]            char_t;

  localparam mag_t MAG_CAP = mag_t'(1) << (VALUE_BITS - 1);
  localparam mag_t MAG_MAX_POS = mag_t'(MAG_CAP - mag_t'(1));

  // largest magnitude that still takes digit d without passing the cap
  localparam mag_t DIGIT_LIMIT [10] = '{
    mag_t'((MAG_CAP - mag_t'(0)) / 10), mag_t'((MAG_CAP - mag_t'(1)) / 10),
    mag_t'((MAG_CAP - mag_t'(2)) / 10), mag_t'((MAG_CAP - mag_t'(3)) / 10),
    mag_t'((MAG_CAP - mag_t'(4)) / 10), mag_t'((MAG_CAP - mag_t'(5)) / 10),
    mag_t'((MAG_CAP - mag_t'(6)) / 10), mag_t'((MAG_CAP - mag_t'(7)) / 10),
    mag_t'((MAG_CAP - mag_t'(8)) / 10), mag_t'((MAG_CAP - mag_t'(9)) / 10)
  };

  localparam char_t CMD_LABEL [4] = '{8'h43, 8'h4D, 8'h44, 8'h3A}; // C M D :
  localparam char_t VAL_LABEL [4] = '{8'h56, 8'h41, 8'h4C, 8'h3A}; // V A L :

  localparam char_t CHAR_SEMI  = 8'h3B;
  localparam char_t CHAR_MINUS = 8'h2D;
  localparam char_t CHAR_PLUS  = 8'h2B;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CMD_MATCH0 = 3'd0,
    CMD_MATCH1 = 3'd1,
    CMD_MATCH2 = 3'd2,
    CMD_MATCH3 = 3'd3,
    CMD_ECHO   = 3'd4,
    CMD_DONE   = 3'd5
  } cmd_phase_t;

  typedef enum logic [2:0] {
    VAL_MATCH0 = 3'd0,
    VAL_MATCH1 = 3'd1,
    VAL_MATCH2 = 3'd2,
    VAL_MATCH3 = 3'd3,
    VAL_SKIP   = 3'd4,
    VAL_DIGITS = 3'd5,
    VAL_DONE   = 3'd6
  } val_phase_t;

  typedef enum logic {
    KIND_CMD_CHAR = 1'b0,
    KIND_SUMMARY  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    char_t              cmd_char;
    logic               cmd_found;
    logic               val_found;
    logic signed [31:0] parsed_value;
  } result_t;

endpackage

// File: rtl/tagged_line_field_parser_unit.sv
// Tagged line field parser, top level: input channel, parser core and a
// two-entry output register. Depends on tlfp_pkg, tlfp_core and the macros header.
//
// Usage: a text line streams in on the s_ channel, one character per transfer;
// a transfer with s_tlast high marks the end of the line (its s_tdata is ignored).
// The bytes after the first "CMD:" come back on m_ as command characters until
// a ';' or the line end. The line end yields one summary result with the found
// flags and the signed value read after the first "VAL:" (spaces skipped, one
// optional sign, digits; saturated at 32-bit bounds).
// Results are registered into the output register (or the skid entry if it is busy).
// Throughput: one character per cycle while s_tready is high; the core updates its
// state in the same cycle that it registers the result.
// Stalls: the output holds a result register plus one skid entry, so input is
// taken while a single result waits; s_tready falls only when both are full.
// Reset: synchronous, clears matcher state and empties the output stage.
`include "tagged_line_field_parser_unit_macros.svh"

module tagged_line_field_parser_unit
  import tlfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,   // line_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_OUT_W-1:0] m_tdata,   // [7:0] cmd_char, [8] cmd_found,
                                           // [9] val_found, [41:10] parsed_value
  output logic [0:0]            m_tuser    // [0] result_kind
);

  logic    in_fire;
  logic    pop;
  logic    push;
  logic    core_valid;
  result_t core_res;

  logic    out_valid, skid_valid;
  result_t out_res, skid_res;

  logic    out_is_char;
  logic    char_fields_ok;

  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;
  assign push     = in_fire && core_valid;

  tlfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (s_tdata),
    .line_end  (s_tlast),
    .res_valid (core_valid),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_res <= core_res;
      end else begin
        skid_res <= core_res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tdata  = {6'b0, out_res.parsed_value, out_res.val_found,
                     out_res.cmd_found, out_res.cmd_char};

  assign out_is_char    = m_tvalid && (m_tuser[0] == KIND_CMD_CHAR);
  assign char_fields_ok = m_tdata[8] && !m_tdata[9] && (m_tdata[41:10] == 32'd0);

  `TLFP_ASSERT_SAME(a_skid_needs_out, clk, rst, skid_valid, out_valid)
  `TLFP_ASSERT_NEXT(a_line_end_gives_result, clk, rst, (in_fire && s_tlast), m_tvalid)
  `TLFP_ASSERT_SAME(a_cmd_char_fields, clk, rst, out_is_char, char_fields_ok)

endmodule

// File: rtl/tlfp_core.sv
// Per-byte step of the parser: both label matchers, the number accumulator
// and the result record for one transfer. Depends on tlfp_pkg.
module tlfp_core
  import tlfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  char_t   data_byte,
  input  logic    line_end,
  output logic    res_valid,
  output result_t res
);

  cmd_phase_t cmd_phase, cmd_phase_next;
  val_phase_t val_phase, val_phase_next;
  logic       negative_sign, negative_sign_next;
  mag_t       magnitude, magnitude_next;

  cmd_phase_t cmd_match;
  val_phase_t val_match;
  logic       is_digit;
  logic [3:0] digit;
  mag_t       mag_added;
  mag_t       mag_pos;
  logic [RES_W-1:0] value_wide;
  logic       cmd_found, val_found;

  assign cmd_match = (data_byte == CMD_LABEL[cmd_phase[1:0]]) ? cmd_phase_t'(cmd_phase + 3'd1)
                   : (data_byte == CMD_LABEL[0]) ? CMD_MATCH1 : CMD_MATCH0;
  assign val_match = (data_byte == VAL_LABEL[val_phase[1:0]]) ? val_phase_t'(val_phase + 3'd1)
                   : (data_byte == VAL_LABEL[0]) ? VAL_MATCH1 : VAL_MATCH0;

  assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign digit     = 4'(data_byte - CHAR_ZERO);
  assign mag_added = (magnitude > DIGIT_LIMIT[digit]) ? MAG_CAP
                   : mag_t'((magnitude << 3) + (magnitude << 1) + mag_t'(digit));

  assign mag_pos    = (magnitude == MAG_CAP) ? MAG_MAX_POS : magnitude;
  assign value_wide = negative_sign ? (RES_W'(0) - RES_W'(magnitude)) : RES_W'(mag_pos);

  assign cmd_found = (cmd_phase == CMD_ECHO) || (cmd_phase == CMD_DONE);
  assign val_found = (val_phase == VAL_SKIP) || (val_phase == VAL_DIGITS)
                  || (val_phase == VAL_DONE);

  always_comb begin
    cmd_phase_next     = cmd_phase;
    val_phase_next     = val_phase;
    negative_sign_next = negative_sign;
    magnitude_next     = magnitude;
    res_valid          = 1'b0;
    res                = '0;
    if (line_end) begin
      res_valid          = 1'b1;
      res.kind           = KIND_SUMMARY;
      res.cmd_found      = cmd_found;
      res.val_found      = val_found;
      res.parsed_value   = val_found ? value_wide[31:0] : 32'sd0;
      cmd_phase_next     = CMD_MATCH0;
      val_phase_next     = VAL_MATCH0;
      negative_sign_next = 1'b0;
      magnitude_next     = '0;
    end else begin
      unique case (cmd_phase)
        CMD_MATCH0, CMD_MATCH1, CMD_MATCH2, CMD_MATCH3: begin
          cmd_phase_next = cmd_match;
        end
        CMD_ECHO: begin
          if (data_byte == CHAR_SEMI) begin
            cmd_phase_next = CMD_DONE;
          end else begin
            res_valid     = 1'b1;
            res.kind      = KIND_CMD_CHAR;
            res.cmd_char  = data_byte;
            res.cmd_found = 1'b1;
          end
        end
        default: ;
      endcase

      unique case (val_phase)
        VAL_MATCH0, VAL_MATCH1, VAL_MATCH2, VAL_MATCH3: begin
          val_phase_next = val_match;
        end
        VAL_SKIP: begin
          priority if (data_byte == CHAR_SPACE) begin
            val_phase_next = VAL_SKIP;
          end else if (data_byte == CHAR_MINUS) begin
            negative_sign_next = 1'b1;
            val_phase_next     = VAL_DIGITS;
          end else if (data_byte == CHAR_PLUS) begin
            val_phase_next = VAL_DIGITS;
          end else if (is_digit) begin
            magnitude_next = mag_added;
            val_phase_next = VAL_DIGITS;
          end else begin
            val_phase_next = VAL_DONE;
          end
        end
        VAL_DIGITS: begin
          if (is_digit) begin
            magnitude_next = mag_added;
          end else begin
            val_phase_next = VAL_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_phase     <= CMD_MATCH0;
      val_phase     <= VAL_MATCH0;
      negative_sign <= 1'b0;
      magnitude     <= '0;
    end else if (in_fire) begin
      cmd_phase     <= cmd_phase_next;
      val_phase     <= val_phase_next;
      negative_sign <= negative_sign_next;
      magnitude     <= magnitude_next;
    end
  end

endmodule

// File: tb/tlfp_line_checker.sv
// Scoreboard for the tagged line field parser: follows every s_ transfer
// through a parser model of its own, queues the results it predicts and checks
// each m_ transfer against the oldest one. Depends on tlfp_pkg.
module tlfp_line_checker
  import tlfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [DATA_OUT_W-1:0] m_tdata,
  input  logic [0:0]            m_tuser,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t       kind;
    char_t       ch;
    logic        cmd_seen;
    logic        val_seen;
    logic [31:0] value;
  } line_result_t;

  localparam longint unsigned MAG_LIMIT = 64'd1 << (VALUE_BITS - 1);

  line_result_t    expected_results [$];
  cmd_phase_t      cmd_ph;
  val_phase_t      val_ph;
  logic            negative;
  longint unsigned mag;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t tlfp mismatch: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic clear_state();
    cmd_ph   = CMD_MATCH0;
    val_ph   = VAL_MATCH0;
    negative = 1'b0;
    mag      = 0;
  endtask

  function automatic longint unsigned with_digit(input longint unsigned m,
                                                 input longint unsigned d);
    if (m > (MAG_LIMIT - d) / 10) return MAG_LIMIT;
    return m * 10 + d;
  endfunction

  function automatic logic [31:0] clamped_value();
    longint unsigned m;
    logic [63:0]     v;
    m = mag;
    if (negative) begin
      if (m > MAG_LIMIT) m = MAG_LIMIT;
      v = 64'd0 - m;
    end else begin
      if (m > MAG_LIMIT - 1) m = MAG_LIMIT - 1;
      v = m;
    end
    return v[31:0];
  endfunction

  task automatic parse_transfer(input char_t b, input logic line_end);
    line_result_t summary;
    line_result_t echo;
    if (line_end) begin
      summary.kind     = KIND_SUMMARY;
      summary.ch       = '0;
      summary.cmd_seen = (cmd_ph >= CMD_ECHO);
      summary.val_seen = (val_ph >= VAL_SKIP);
      summary.value    = summary.val_seen ? clamped_value() : '0;
      expected_results.insert(expected_results.size(), summary);
      clear_state();
      return;
    end

    case (cmd_ph)
      CMD_ECHO: begin
        if (b == CHAR_SEMI) begin
          cmd_ph = CMD_DONE;
        end else begin
          echo.kind     = KIND_CMD_CHAR;
          echo.ch       = b;
          echo.cmd_seen = 1'b1;
          echo.val_seen = 1'b0;
          echo.value    = '0;
          expected_results.insert(expected_results.size(), echo);
        end
      end
      CMD_DONE: ;
      default: begin
        if (b == CMD_LABEL[int'(cmd_ph)]) cmd_ph = cmd_phase_t'(int'(cmd_ph) + 1);
        else cmd_ph = (b == CMD_LABEL[0]) ? CMD_MATCH1 : CMD_MATCH0;
      end
    endcase

    case (val_ph)
      VAL_SKIP: begin
        if (b == CHAR_MINUS) begin
          negative = 1'b1;
          val_ph   = VAL_DIGITS;
        end else if (b == CHAR_PLUS) begin
          val_ph = VAL_DIGITS;
        end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          mag    = with_digit(mag, b - CHAR_ZERO);
          val_ph = VAL_DIGITS;
        end else if (b != CHAR_SPACE) begin
          val_ph = VAL_DONE;
        end
      end
      VAL_DIGITS: begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) mag = with_digit(mag, b - CHAR_ZERO);
        else val_ph = VAL_DONE;
      end
      VAL_DONE: ;
      default: begin
        if (b == VAL_LABEL[int'(val_ph)]) val_ph = val_phase_t'(int'(val_ph) + 1);
        else val_ph = (b == VAL_LABEL[0]) ? VAL_MATCH1 : VAL_MATCH0;
      end
    endcase
  endtask

  task automatic check_result();
    line_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, tdata low", m_tdata[31:0], '0);
      return;
    end
    want = expected_results.pop_front();
    if (m_tuser[0] !== want.kind)
      report_mismatch("result_kind", 32'(m_tuser[0]), 32'(want.kind));
    if (m_tdata[7:0] !== want.ch)
      report_mismatch("cmd_char", 32'(m_tdata[7:0]), 32'(want.ch));
    if (m_tdata[8] !== want.cmd_seen)
      report_mismatch("cmd_found", 32'(m_tdata[8]), 32'(want.cmd_seen));
    if (m_tdata[9] !== want.val_seen)
      report_mismatch("val_found", 32'(m_tdata[9]), 32'(want.val_seen));
    if (m_tdata[41:10] !== want.value)
      report_mismatch("parsed_value", m_tdata[41:10], want.value);
  endtask

  // a result is registered before it can leave, so check before predicting
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) parse_transfer(s_tdata, s_tlast);
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/tb_tagged_line_field_parser_unit.sv
// Testbench top for tagged_line_field_parser_unit: drives text lines with
// random gaps and back-pressure and gives the verdict. Depends on tlfp_pkg,
// the RTL and tlfp_line_checker.
module tb_tagged_line_field_parser_unit
  import tlfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 170;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = 8'h00;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_OUT_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  int errors;
  int pending;
  int items_sent    = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 47;
  int cycle_count   = 0;

  logic [7:0] line_q [$];

  tagged_line_field_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  tlfp_line_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_tagged_line_field_parser_unit: done, errors");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  task automatic queue_char(input logic [7:0] c);
    line_q.insert(line_q.size(), c);
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0, 1: return 8'($urandom_range(1, 255));
      2:    return CMD_LABEL[$urandom_range(0, 3)];
      3:    return VAL_LABEL[$urandom_range(0, 3)];
      4: begin
        case ($urandom_range(0, 4))
          0:       return CHAR_SEMI;
          1:       return CHAR_SPACE;
          2:       return CHAR_MINUS;
          3:       return CHAR_PLUS;
          default: return 8'h0A;
        endcase
      end
      default: return 8'(CHAR_ZERO + $urandom_range(0, 9));
    endcase
  endfunction

  task automatic queue_text(input string t);
    for (int i = 0; i < t.len(); i++) queue_char(t[i]);
  endtask

  // partial labels now and then
  task automatic add_label(input bit is_cmd);
    int n;
    n = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 4;
    for (int i = 0; i < n; i++) queue_char(is_cmd ? CMD_LABEL[i] : VAL_LABEL[i]);
    if (n < 4) queue_char(noise_char());
  endtask

  task automatic add_command();
    add_label(1'b1);
    repeat ($urandom_range(0, 5)) queue_char(noise_char());
    if ($urandom_range(0, 99) < 70) queue_char(CHAR_SEMI);
  endtask

  task automatic add_value();
    add_label(1'b0);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) queue_char(CHAR_SPACE);
    case ($urandom_range(0, 2))
      0:       queue_char(CHAR_MINUS);
      1:       queue_char(CHAR_PLUS);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        case ($urandom_range(0, 2))
          0:       queue_text("2147483647");
          1:       queue_text("2147483648");
          default: queue_text("2147483649");
        endcase
      end
      2, 3:    repeat ($urandom_range(9, 14)) queue_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
      default: repeat ($urandom_range(1, 5)) queue_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
    endcase
    if ($urandom_range(0, 1) == 1) queue_char(noise_char());
  endtask

  task automatic make_line();
    bit cmd_first;
    line_q.delete();
    repeat ($urandom_range(0, 2)) queue_char(noise_char());
    cmd_first = $urandom_range(0, 1);
    if (cmd_first && $urandom_range(0, 99) < 70) add_command();
    if ($urandom_range(0, 99) < 70) add_value();
    if (!cmd_first && $urandom_range(0, 99) < 70) add_command();
    repeat ($urandom_range(0, 2)) queue_char(noise_char());
  endtask

  // entered and left at a falling edge
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= last ? 8'($urandom_range(1, 255)) : b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i], 1'b0);
    send_item(8'h00, 1'b1);
    line_q.delete();
  endtask

  initial begin
    int goal;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // extreme bytes echoed, command closed by ';', label restart, sign alone
    queue_text("CMD:");
    queue_char(8'h01);
    queue_char(8'hFF);
    queue_text(";VVAL:+");
    send_line();
    // saturation
    queue_text("VAL:9999999999");
    send_line();

    goal = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 37 : 0;
      goal += PHASE_ITEMS;
      while (items_sent < goal) begin
        make_line();
        send_line();
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_tagged_line_field_parser_unit: done, clean");
    end else begin
      $display("tb_tagged_line_field_parser_unit: done, errors");
    end
    $finish;
  end

endmodule
